@@ rtl/jts_pkg.sv @@
// jts_pkg: types, codes and helper functions of the json token scanner
// used by json_token_scanner; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

  localparam int POS_BITS = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  typedef logic [POS_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  // scan modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_STR  = 2'd2;
  localparam logic [1:0] MODE_ESC  = 2'd3;

  // number classes
  localparam logic [3:0] NC_UND    = 4'd0;
  localparam logic [3:0] NC_SIGNED = 4'd1;
  localparam logic [3:0] NC_DOT    = 4'd2;
  localparam logic [3:0] NC_I1     = 4'd3;
  localparam logic [3:0] NC_I2     = 4'd4;
  localparam logic [3:0] NC_N1     = 4'd5;
  localparam logic [3:0] NC_N2     = 4'd6;
  localparam logic [3:0] NC_INT    = 4'd7;
  localparam logic [3:0] NC_REAL   = 4'd8;
  localparam logic [3:0] NC_BAD    = 4'd9;

  // record types
  localparam logic [1:0] REC_TOKEN   = 2'd0;
  localparam logic [1:0] REC_CONTENT = 2'd1;
  localparam logic [1:0] REC_ERROR   = 2'd2;

  // token kinds
  localparam logic [3:0] TK_LBRACE = 4'd0;
  localparam logic [3:0] TK_RBRACE = 4'd1;
  localparam logic [3:0] TK_LBRACK = 4'd2;
  localparam logic [3:0] TK_RBRACK = 4'd3;
  localparam logic [3:0] TK_STRING = 4'd4;
  localparam logic [3:0] TK_COLON  = 4'd5;
  localparam logic [3:0] TK_COMMA  = 4'd6;
  localparam logic [3:0] TK_NULL   = 4'd7;
  localparam logic [3:0] TK_TRUE   = 4'd8;
  localparam logic [3:0] TK_FALSE  = 4'd9;
  localparam logic [3:0] TK_INT    = 4'd10;
  localparam logic [3:0] TK_REAL   = 4'd11;

  // error codes
  localparam logic ERR_WORD   = 1'b0;
  localparam logic ERR_STRING = 1'b1;

  // characters
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_I  = 8'h69;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef struct packed {
    logic [1:0]  rec_type;
    logic [3:0]  token_kind;
    logic        error_code;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [7:0]  content_byte;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [3:0] len;
    logic [2:0] hits;
    logic [3:0] nclass;
  } word_t;

  localparam word_t WORD_FRESH = '{len: 4'd0, hits: 3'b111, nclass: NC_UND};

  function automatic logic [15:0] pos_field(input pos_t p);
    logic [POS_BITS+15:0] w;
    w = {16'b0, p};
    return w[15:0];
  endfunction

  function automatic rec_t make_rec(input logic [1:0] rtype, input logic [3:0] kind,
                                    input logic err, input pos_t line, input pos_t col,
                                    input logic [7:0] data);
    rec_t r;
    r.rec_type      = rtype;
    r.token_kind    = kind;
    r.error_code    = err;
    r.line_number   = pos_field(line);
    r.column_number = pos_field(col);
    r.content_byte  = data;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // {is structural, token kind}
  function automatic logic [4:0] struct_kind(input logic [7:0] b);
    logic [4:0] r;
    case (b)
      CH_LBRACE: r = {1'b1, TK_LBRACE};
      CH_RBRACE: r = {1'b1, TK_RBRACE};
      CH_LBRACK: r = {1'b1, TK_LBRACK};
      CH_RBRACK: r = {1'b1, TK_RBRACK};
      CH_COLON:  r = {1'b1, TK_COLON};
      CH_COMMA:  r = {1'b1, TK_COMMA};
      CH_QUOTE:  r = {1'b1, TK_STRING};
      default:   r = 5'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] c;
    case ({k, p})
      5'b00_000: c = "n";
      5'b00_001: c = "u";
      5'b00_010: c = "l";
      5'b00_011: c = "l";
      5'b01_000: c = "t";
      5'b01_001: c = "r";
      5'b01_010: c = "u";
      5'b01_011: c = "e";
      5'b10_000: c = "f";
      5'b10_001: c = "a";
      5'b10_010: c = "l";
      5'b10_011: c = "s";
      5'b10_100: c = "e";
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    return (k == 2'd2) ? 4'd5 : 4'd4;
  endfunction

  // adds one byte to a word under scan
  function automatic word_t word_step(input word_t s, input logic [7:0] b);
    word_t n;
    logic digit;
    logic [7:0] lb;
    n = s;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    lb = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_GAP : b;
    for (int k = 0; k < 3; k++) begin
      if (s.len >= kw_len(2'(k)) || kw_char(2'(k), s.len[2:0]) != b) begin
        n.hits[k] = 1'b0;
      end
    end
    if (s.len != 4'hf) begin
      n.len = s.len + 4'd1;
    end
    case (s.nclass)
      NC_UND, NC_SIGNED: begin
        if (s.nclass == NC_UND && (b == CH_PLUS || b == CH_MINUS)) n.nclass = NC_SIGNED;
        else if (digit) n.nclass = NC_INT;
        else if (b == CH_DOT) n.nclass = NC_DOT;
        else if (lb == CH_LOW_I) n.nclass = NC_I1;
        else if (lb == CH_LOW_N) n.nclass = NC_N1;
        else n.nclass = NC_BAD;
      end
      NC_DOT: n.nclass = digit ? NC_REAL : NC_BAD;
      NC_I1:  n.nclass = (lb == CH_LOW_N) ? NC_I2 : NC_BAD;
      NC_I2:  n.nclass = (lb == CH_LOW_F) ? NC_REAL : NC_BAD;
      NC_N1:  n.nclass = (lb == CH_LOW_A) ? NC_N2 : NC_BAD;
      NC_N2:  n.nclass = (lb == CH_LOW_N) ? NC_REAL : NC_BAD;
      default: n.nclass = s.nclass;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/json_token_scanner.sv @@
// json_token_scanner: streaming json lexer, one text byte per item
// depends on jts_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
// in channel: in_text_byte with in_end_marker; an item is taken at a clock edge
//   with in_valid high and in_stall low. in_end_marker flushes a pending word or
//   reports an open string; positions are kept across it.
// out channel: one record per transfer (token, string content byte or error);
//   out_last marks the final record caused by one input item. An item causes
//   zero, one or two records.
// records: with the result queue empty, the first record of an item is on the
//   output in the cycle after the item is taken; a second one follows once the first is taken.
// throughput: one item per cycle while items cause at most one record each; the
//   output moves one record per cycle when not stalled. The scanner state is
//   updated in the cycle of acceptance and records go into a four-entry result
//   queue; in_stall is high while fewer than two queue slots are free, so a
//   receiver stall holds the head and stalls the input once three records wait.
// after an error the scanner takes items but emits nothing until reset.
// reset: synchronous on rst_n low; line and column return to one, the queue
//   empties, the mode returns to idle.
module json_token_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_marker,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_rec_type,
  output logic [3:0]       out_token_kind,
  output logic             out_error_code,
  output logic [15:0]      out_line_number,
  output logic [15:0]      out_column_number,
  output logic [7:0]       out_content_byte,
  output logic             out_last
);
  import jts_pkg::*;

  logic [1:0]          mode_r, mode_nxt;
  pos_t                cur_line_r, cur_line_nxt;
  pos_t                cur_col_r, cur_col_nxt;
  pos_t                tok_line_r, tok_line_nxt;
  pos_t                tok_col_r, tok_col_nxt;
  word_t               word_r, word_nxt;
  logic                halted_r, halted_nxt;

  rec_t                fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]    cnt_r;

  logic                in_acc, out_pop;
  logic [1:0]          n_push;
  rec_t                rec0, rec1;

  logic [7:0]          b;
  logic                sp;
  logic [4:0]          sk;
  logic                wf_err;
  logic [3:0]          wf_kind;
  rec_t                wf_rec;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = cnt_r > (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_pop   = out_valid && !out_stall;

  assign out_rec_type      = fifo_r[rd_ptr_r].rec_type;
  assign out_token_kind    = fifo_r[rd_ptr_r].token_kind;
  assign out_error_code    = fifo_r[rd_ptr_r].error_code;
  assign out_line_number   = fifo_r[rd_ptr_r].line_number;
  assign out_column_number = fifo_r[rd_ptr_r].column_number;
  assign out_content_byte  = fifo_r[rd_ptr_r].content_byte;
  assign out_last          = fifo_r[rd_ptr_r].last;

  assign b  = in_text_byte;
  assign sp = is_space(b);
  assign sk = struct_kind(b);

  // classification of the word held in word_r
  always_comb begin
    wf_err  = 1'b0;
    wf_kind = TK_NULL;
    if (word_r.hits[0] && word_r.len == 4'd4) wf_kind = TK_NULL;
    else if (word_r.hits[1] && word_r.len == 4'd4) wf_kind = TK_TRUE;
    else if (word_r.hits[2] && word_r.len == 4'd5) wf_kind = TK_FALSE;
    else if (word_r.nclass == NC_INT) wf_kind = TK_INT;
    else if (word_r.nclass == NC_REAL) wf_kind = TK_REAL;
    else wf_err = 1'b1;
    wf_rec = wf_err ? make_rec(REC_ERROR, TK_LBRACE, ERR_WORD, tok_line_r, tok_col_r, 8'h00)
                    : make_rec(REC_TOKEN, wf_kind, ERR_WORD, tok_line_r, tok_col_r, 8'h00);
  end

  always_comb begin
    logic start_scan;
    logic s_has;
    rec_t s_rec;
    mode_nxt     = mode_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    word_nxt     = word_r;
    halted_nxt   = halted_r;
    n_push       = 2'd0;
    rec0         = '0;
    rec1         = '0;
    start_scan   = 1'b0;
    s_has        = 1'b0;
    s_rec        = '0;
    if (in_acc && !halted_r) begin
      if (in_end_marker) begin
        if (mode_r == MODE_WORD) begin
          rec0   = wf_rec;
          n_push = 2'd1;
          if (wf_err) halted_nxt = 1'b1;
        end else if (mode_r == MODE_STR || mode_r == MODE_ESC) begin
          rec0 = make_rec(REC_ERROR, TK_LBRACE, ERR_STRING, cur_line_r, cur_col_r, 8'h00);
          n_push     = 2'd1;
          halted_nxt = 1'b1;
        end
        mode_nxt = MODE_IDLE;
      end else begin
        case (mode_r)
          MODE_ESC: begin
            rec0     = make_rec(REC_CONTENT, TK_LBRACE, ERR_WORD, cur_line_r, cur_col_r, b);
            n_push   = 2'd1;
            mode_nxt = MODE_STR;
          end
          MODE_STR: begin
            if (b == CH_QUOTE) begin
              rec0 = make_rec(REC_TOKEN, TK_STRING, ERR_WORD, tok_line_r, tok_col_r, 8'h00);
              n_push   = 2'd1;
              mode_nxt = MODE_IDLE;
            end else if (b == CH_BSLASH) begin
              mode_nxt = MODE_ESC;
            end else begin
              rec0 = make_rec(REC_CONTENT, TK_LBRACE, ERR_WORD, cur_line_r, cur_col_r, b);
              n_push = 2'd1;
            end
          end
          default: begin
            start_scan = 1'b1;
            if (mode_r == MODE_WORD) begin
              if (!sp && !sk[4]) begin
                word_nxt   = word_step(word_r, b);
                start_scan = 1'b0;
              end else begin
                rec0     = wf_rec;
                n_push   = 2'd1;
                mode_nxt = MODE_IDLE;
                if (wf_err) begin
                  halted_nxt = 1'b1;
                  start_scan = 1'b0;
                end
              end
            end
          end
        endcase

        if (start_scan && !sp) begin
          if (b == CH_QUOTE) begin
            tok_line_nxt = cur_line_r;
            tok_col_nxt  = cur_col_r;
            mode_nxt     = MODE_STR;
          end else if (sk[4]) begin
            s_has = 1'b1;
            s_rec = make_rec(REC_TOKEN, sk[3:0], ERR_WORD, cur_line_r, cur_col_r, 8'h00);
          end else begin
            tok_line_nxt = cur_line_r;
            tok_col_nxt  = cur_col_r;
            word_nxt     = word_step(WORD_FRESH, b);
            mode_nxt     = MODE_WORD;
          end
        end
        if (s_has) begin
          if (n_push == 2'd0) rec0 = s_rec;
          else rec1 = s_rec;
          n_push = n_push + 2'd1;
        end

        // position tracking
        if (b == CH_LF) begin
          if (cur_line_r != POS_MAX) cur_line_nxt = cur_line_r + pos_t'(1);
          cur_col_nxt = pos_t'(1);
        end else if (cur_col_r != POS_MAX) begin
          cur_col_nxt = cur_col_r + pos_t'(1);
        end
      end
      if (n_push == 2'd1) rec0.last = 1'b1;
      if (n_push == 2'd2) rec1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      cur_line_r <= pos_t'(1);
      cur_col_r  <= pos_t'(1);
      tok_line_r <= '0;
      tok_col_r  <= '0;
      word_r     <= WORD_FRESH;
      halted_r   <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      mode_r     <= mode_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      word_r     <= word_nxt;
      halted_r   <= halted_nxt;
      wr_ptr_r   <= wr_ptr_r + FIFO_AW'(n_push);
      rd_ptr_r   <= rd_ptr_r + FIFO_AW'(out_pop);
      cnt_r      <= cnt_r + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(out_pop);
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= rec0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= rec1;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |-> (cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2)))
    else $error("records pushed without room");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> (halted_r && n_push == 2'd0))
    else $error("halted scanner resumed");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0 && rec0.rec_type == REC_ERROR) |=> halted_r)
    else $error("error record without halt");

  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push == 2'd2) |-> (!rec0.last && rec1.last))
    else $error("last flag misplaced on a record pair");
`endif

endmodule

`default_nettype wire
